FILE: rtl/binary_erosion_5x5_stream_defines.svh
// Assertion helpers used by the top-level erosion module.
`ifndef BINARY_EROSION_5X5_STREAM_DEFINES_SVH
`define BINARY_EROSION_5X5_STREAM_DEFINES_SVH

// Same-cycle implication.
`define BE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("erosion block assertion failed");

// Next-cycle implication.
`define BE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("erosion block assertion failed");

`endif

FILE: rtl/bin_ero_pkg.sv
`timescale 1ns / 1ps

package bin_ero_pkg;

	localparam int WIN       = 5;
	localparam int RAD       = WIN / 2;
	localparam int AREA      = WIN * WIN;
	localparam int LINE_W    = WIN - 1;
	localparam int CENTER    = RAD * WIN + RAD;
	localparam int DIM_W     = 11;
	localparam int POS_W     = 10;
	localparam int CFG_W     = 25;
	localparam int IDX_W     = 2;

	localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_ELEMENT = 2'd2,
		REG_INVERT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic operation;
		logic pixel_value;
	} in_word_t;

	typedef struct packed {
		logic             out_pixel;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             last_of_frame;
	} out_word_t;

	typedef struct packed {
		logic advance;
		logic pixel;
		logic interior;
	} win_ctl_t;

endpackage

FILE: rtl/bin_ero_stream_if.sv
`timescale 1ns / 1ps

interface bin_ero_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bin_ero_line_ram.sv
`timescale 1ns / 1ps

module bin_ero_line_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 4,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/bin_ero_window.sv
`timescale 1ns / 1ps

module bin_ero_window (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bin_ero_pkg::win_ctl_t           ctl,
	input  logic [bin_ero_pkg::LINE_W-1:0]  line_word,
	input  logic [bin_ero_pkg::AREA-1:0]    element,
	input  logic                            invert,
	output logic [bin_ero_pkg::LINE_W-1:0]  line_next,
	output logic                            keep_pixel
);

	localparam int WIN    = bin_ero_pkg::WIN;
	localparam int AREA   = bin_ero_pkg::AREA;
	localparam int LINE_W = bin_ero_pkg::LINE_W;

	logic [AREA-1:0] window_q;
	logic [AREA-1:0] win_next;
	logic            match;

	always_comb begin
		for (int j = 0; j < WIN; j++) begin
			if (j == WIN - 1) begin
				win_next[j*WIN +: WIN] = {ctl.pixel, window_q[j*WIN+1 +: WIN-1]};
			end else begin
				win_next[j*WIN +: WIN] = {line_word[WIN-2-j], window_q[j*WIN+1 +: WIN-1]};
			end
		end
	end

	assign line_next  = {line_word[LINE_W-2:0], ctl.pixel};
	assign match      = (win_next ^ {AREA{invert}}) == element;
	assign keep_pixel = ctl.interior & match & (win_next[bin_ero_pkg::CENTER] ^ invert);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (ctl.advance) begin
			window_q <= win_next;
		end
	end

endmodule

FILE: rtl/binary_erosion_5x5_stream.sv
`timescale 1ns / 1ps
// 5x5 binary erosion over a raster stream of 1-bit pixels.
// pixels: sink channel, one word per pixel (operation 0) or flush (operation 1).
// results: source channel, one word per output position, lagging the input by
//   two rows plus two pixels; flush words after the last pixel drain the tail,
//   and the word for the frame's final position carries last_of_frame.
// Config: wr_en/wr_index/wr_data write image_width, image_height,
//   structuring_element and invert_mode; write only while no word is in flight.
// Throughput: one word per cycle when results are not held back and no clearing
//   pass runs. Path: a taken pixel is registered in stage 1 with its line RAM
//   read; the window update and the output register then load together.
// The line RAM holds four past rows per column, one read and one write port;
//   back-to-back accesses to the same column are forwarded.
// Reset: a clearing pass zeroes each of the MAX_WIDTH line RAM entries, with
//   pixels.ready low; config writes are taken during it.
// Stall: a held result keeps the output register; the stage behind it and the
//   input hold as well, so no word is lost or repeated.
`include "binary_erosion_5x5_stream_defines.svh"

module binary_erosion_5x5_stream #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bin_ero_stream_if.sink                    pixels,
	bin_ero_stream_if.source                  results,
	input  logic                              wr_en,
	input  logic [bin_ero_pkg::IDX_W-1:0]     wr_index,
	input  logic [bin_ero_pkg::CFG_W-1:0]     wr_data
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int QW     = WW + 1;
	localparam int PW     = HW + 1;
	localparam int LW     = WW + 2;
	localparam int DIM_W  = bin_ero_pkg::DIM_W;
	localparam int POS_W  = bin_ero_pkg::POS_W;
	localparam int AREA   = bin_ero_pkg::AREA;
	localparam int LINE_W = bin_ero_pkg::LINE_W;
	localparam int RAD    = bin_ero_pkg::RAD;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [AREA-1:0]  element_q;
	logic             invert_q;

	logic [HW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] out_row_q;
	logic [CW-1:0] out_col_q;

	logic          clr_busy_q;
	logic [CW-1:0] clr_q;

	logic              valid_s1;
	logic              push_s1;
	logic              emit_s1;
	logic              interior_s1;
	logic              last_s1;
	logic              pixel_s1;
	logic [POS_W-1:0]  row_s1;
	logic [POS_W-1:0]  col_s1;
	logic [CW-1:0]     lcol_s1;
	logic              fwd_s1;
	logic [LINE_W-1:0] fwd_data_s1;

	logic                   res_valid_q;
	bin_ero_pkg::out_word_t res_q;

	logic [WW-1:0]     w_eff;
	logic [HW-1:0]     h_eff;
	logic              frame_done;
	logic              out_free;
	logic              s1_go;
	logic              acc;
	logic              is_flush;
	logic              take_pix;
	logic              take_fl;
	logic              push;
	logic              lag_ok;
	logic              interior;
	logic              in_col_wrap;
	logic              out_col_wrap;
	logic              last_fl;
	logic [LW-1:0]     colx;
	logic [LW-1:0]     wl;
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line_word;
	logic [LINE_W-1:0] line_next;
	logic              keep_pixel;
	logic              ram_we;
	logic [CW-1:0]     ram_waddr;
	logic [LINE_W-1:0] ram_wdata;
	bin_ero_pkg::win_ctl_t win_ctl;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= bin_ero_pkg::DIM_RESET;
			height_q  <= bin_ero_pkg::DIM_RESET;
			element_q <= '0;
			invert_q  <= 1'b0;
		end else if (wr_en) begin
			case (bin_ero_pkg::reg_idx_t'(wr_index))
				bin_ero_pkg::REG_WIDTH:   width_q   <= wr_data[DIM_W-1:0];
				bin_ero_pkg::REG_HEIGHT:  height_q  <= wr_data[DIM_W-1:0];
				bin_ero_pkg::REG_ELEMENT: element_q <= wr_data[AREA-1:0];
				bin_ero_pkg::REG_INVERT:  invert_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	// handshake and item decode
	assign frame_done = in_row_q >= h_eff;
	assign out_free   = !res_valid_q || results.ready;
	assign s1_go      = !(valid_s1 && emit_s1) || out_free;
	assign pixels.ready = !clr_busy_q && (!valid_s1 || s1_go);
	assign acc        = pixels.valid && pixels.ready;
	assign is_flush   = pixels.data.operation == bin_ero_pkg::OP_FLUSH;
	assign take_pix   = acc && !is_flush && !frame_done;
	assign take_fl    = acc && is_flush && frame_done;
	assign push       = valid_s1 && push_s1 && s1_go;

	assign in_col_wrap  = (QW'(in_col_q) + QW'(1)) >= QW'(w_eff);
	assign out_col_wrap = (QW'(out_col_q) + QW'(1)) >= QW'(w_eff);
	assign last_fl      = ((PW'(out_row_q) + PW'(1)) >= PW'(h_eff)) && out_col_wrap;

	assign interior = (PW'(out_row_q) >= PW'(RAD)) &&
	                  ((PW'(out_row_q) + PW'(RAD)) < PW'(h_eff)) &&
	                  (QW'(out_col_q) >= QW'(RAD)) &&
	                  ((QW'(out_col_q) + QW'(RAD)) < QW'(w_eff));

	// position reached two rows plus two pixels into the frame
	assign colx = LW'(in_col_q);
	assign wl   = LW'(w_eff);

	always_comb begin
		if (in_row_q >= HW'(4)) begin
			lag_ok = 1'b1;
		end else if (in_row_q == HW'(3)) begin
			lag_ok = (w_eff >= WW'(2)) || (in_col_q != '0);
		end else if (in_row_q == HW'(2)) begin
			lag_ok = colx >= LW'(2);
		end else if (in_row_q == HW'(1)) begin
			lag_ok = colx >= (wl + LW'(2));
		end else begin
			lag_ok = colx >= ((wl << 1) + LW'(2));
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (take_fl) begin
			if (last_fl) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else if (out_col_wrap) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + RW'(1);
			end else begin
				out_col_q <= out_col_q + CW'(1);
			end
		end else if (take_pix) begin
			if (in_col_wrap) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + HW'(1);
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
			if (lag_ok) begin
				if (out_col_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// line RAM clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + CW'(1);
			if (clr_q == CW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= take_pix || take_fl;
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.ready) begin
			push_s1     <= take_pix;
			emit_s1     <= take_fl || (take_pix && lag_ok);
			interior_s1 <= take_pix && interior;
			last_s1     <= take_fl && last_fl;
			pixel_s1    <= pixels.data.pixel_value;
			row_s1      <= POS_W'(out_row_q);
			col_s1      <= POS_W'(out_col_q);
			lcol_s1     <= in_col_q;
			fwd_s1      <= push && (lcol_s1 == in_col_q);
			fwd_data_s1 <= line_next;
		end
	end

	assign ram_we    = clr_busy_q || push;
	assign ram_waddr = clr_busy_q ? clr_q : lcol_s1;
	assign ram_wdata = clr_busy_q ? '0 : line_next;

	bin_ero_line_ram #(
		.DEPTH (MAX_WIDTH),
		.DW    (LINE_W),
		.AW    (CW)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (take_pix),
		.raddr (in_col_q),
		.rdata (ram_rdata)
	);

	assign line_word = fwd_s1 ? fwd_data_s1 : ram_rdata;

	assign win_ctl.advance  = push;
	assign win_ctl.pixel    = pixel_s1;
	assign win_ctl.interior = interior_s1;

	bin_ero_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (win_ctl),
		.line_word  (line_word),
		.element    (element_q),
		.invert     (invert_q),
		.line_next  (line_next),
		.keep_pixel (keep_pixel)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			res_q.out_pixel     <= keep_pixel;
			res_q.out_row       <= row_s1;
			res_q.out_col       <= col_s1;
			res_q.last_of_frame <= last_s1;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	`BE_ASSERT_IMPL(a_no_take_in_clear, clk, arst_n, clr_busy_q, !pixels.ready)
	`BE_ASSERT_IMPL(a_stall_from_output, clk, arst_n, valid_s1 && !s1_go, results.valid && !results.ready)
	`BE_ASSERT_NEXT(a_last_clears_pos, clk, arst_n, take_fl && last_fl, in_row_q == '0 && in_col_q == '0 && out_row_q == '0 && out_col_q == '0)

endmodule

FILE: bench/binary_erosion_5x5_stream_tb.sv
`timescale 1ns / 1ps

module binary_erosion_5x5_stream_tb;

	localparam int MAX_DIM       = 1024;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDX_W         = bin_ero_pkg::IDX_W;
	localparam int CFG_W         = bin_ero_pkg::CFG_W;
	localparam int DIM_W         = bin_ero_pkg::DIM_W;
	localparam int AREA          = bin_ero_pkg::AREA;
	localparam int LINE_W        = bin_ero_pkg::LINE_W;
	localparam int POS_W         = bin_ero_pkg::POS_W;
	localparam int WIN           = bin_ero_pkg::WIN;
	localparam int RAD           = bin_ero_pkg::RAD;
	localparam int CENTER        = bin_ero_pkg::CENTER;

	typedef enum int {PAT_RANDOM, PAT_TILED, PAT_SOLID} pattern_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	bin_ero_stream_if #(.word_t(bin_ero_pkg::in_word_t))  pix_if ();
	bin_ero_stream_if #(.word_t(bin_ero_pkg::out_word_t)) res_if ();

	binary_erosion_5x5_stream dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pix_if),
		.results  (res_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	logic [DIM_W-1:0]  ero_width;
	logic [DIM_W-1:0]  ero_height;
	logic [AREA-1:0]   ero_element;
	logic              ero_invert;
	logic [LINE_W-1:0] line_hist [MAX_DIM];
	logic [AREA-1:0]   win_bits;
	int unsigned       in_row, in_col, out_row, out_col;

	bin_ero_pkg::out_word_t expected_words [$];
	int          error_count = 0;
	int          counted_items = 0;
	int          source_idle_pct = 0;
	int          sink_idle_pct = 0;
	pattern_t    pixel_pattern = PAT_RANDOM;
	int          flip_pct = 0;

	always #4 clk = ~clk;

	function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic bit frame_input_done();
		return in_row >= clamp_dim(ero_height);
	endfunction

	function automatic void step_pos(inout int unsigned row, inout int unsigned col,
			input int unsigned w);
		if (col + 1 >= w) begin
			col = 0;
			row = row + 1;
		end else begin
			col = col + 1;
		end
	endfunction

	function automatic void reset_erosion_model();
		ero_width   = bin_ero_pkg::DIM_RESET;
		ero_height  = bin_ero_pkg::DIM_RESET;
		ero_element = '0;
		ero_invert  = 1'b0;
		foreach (line_hist[i])
			line_hist[i] = '0;
		win_bits = '0;
		in_row   = 0;
		in_col   = 0;
		out_row  = 0;
		out_col  = 0;
	endfunction

	function automatic void apply_config(bin_ero_pkg::reg_idx_t idx, logic [CFG_W-1:0] value);
		case (idx)
			bin_ero_pkg::REG_WIDTH:   ero_width = value[DIM_W-1:0];
			bin_ero_pkg::REG_HEIGHT:  ero_height = value[DIM_W-1:0];
			bin_ero_pkg::REG_ELEMENT: ero_element = value[AREA-1:0];
			bin_ero_pkg::REG_INVERT:  ero_invert = value[0];
			default: ;
		endcase
	endfunction

	// Returns 1 when the word is not ignored.
	function automatic bit predict_erosion(bin_ero_pkg::in_word_t word);
		int unsigned       w, h, lin, lag, r, c;
		int                j;
		bit                last_pos, interior;
		logic              val, nb;
		logic [LINE_W-1:0] hist;
		logic [AREA-1:0]   nw, inv_mask;
		logic [WIN-1:0]    rb;
		bin_ero_pkg::out_word_t res;
		w = clamp_dim(ero_width);
		h = clamp_dim(ero_height);
		if (word.operation == bin_ero_pkg::OP_FLUSH) begin
			if (in_row < h)
				return 0;
			last_pos = (out_row + 1 >= h) && (out_col + 1 >= w);
			res.out_pixel     = 1'b0;
			res.out_row       = out_row[POS_W-1:0];
			res.out_col       = out_col[POS_W-1:0];
			res.last_of_frame = last_pos;
			expected_words.push_back(res);
			if (last_pos) begin
				in_row  = 0;
				in_col  = 0;
				out_row = 0;
				out_col = 0;
			end else begin
				step_pos(out_row, out_col, w);
			end
			return 1;
		end
		if (in_row >= h)
			return 0;
		lin  = in_row * w + in_col;
		lag  = RAD * w + RAD;
		hist = line_hist[in_col];
		nw   = '0;
		for (j = 0; j < WIN; j++) begin
			rb = win_bits[j*WIN +: WIN];
			if (j == WIN - 1)
				nb = word.pixel_value;
			else
				nb = hist[WIN-2-j];
			nw[j*WIN +: WIN] = {nb, rb[WIN-1:1]};
		end
		win_bits = nw;
		line_hist[in_col] = {hist[LINE_W-2:0], word.pixel_value};
		step_pos(in_row, in_col, w);
		if (lin >= lag) begin
			r = out_row;
			c = out_col;
			interior = r >= RAD && r + RAD < h && c >= RAD && c + RAD < w;
			inv_mask = ero_invert ? '1 : '0;
			val = 1'b0;
			if (interior && ((win_bits ^ inv_mask) == ero_element))
				val = win_bits[CENTER] ^ ero_invert;
			res.out_pixel     = val;
			res.out_row       = r[POS_W-1:0];
			res.out_col       = c[POS_W-1:0];
			res.last_of_frame = 1'b0;
			expected_words.push_back(res);
			step_pos(out_row, out_col, w);
		end
		return 1;
	endfunction

	function automatic logic pattern_pixel(int unsigned r, int unsigned c);
		case (pixel_pattern)
			PAT_TILED:
				return ero_element[(r % WIN) * WIN + c % WIN] ^ ero_invert ^
					($urandom_range(99) < flip_pct);
			PAT_SOLID:
				return ero_element[CENTER] ^ ero_invert;
			default:
				return 1'($urandom_range(1));
		endcase
	endfunction

	task automatic check_result(bin_ero_pkg::out_word_t got);
		bin_ero_pkg::out_word_t exp_word;
		if (expected_words.size() == 0) begin
			$error("unexpected result word: row %0d col %0d", got.out_row, got.out_col);
			error_count++;
			return;
		end
		exp_word = expected_words.pop_front();
		if (got.out_pixel !== exp_word.out_pixel) begin
			$error("out_pixel: expected %0d, actual %0d", exp_word.out_pixel, got.out_pixel);
			error_count++;
		end
		if (got.out_row !== exp_word.out_row) begin
			$error("out_row: expected %0d, actual %0d", exp_word.out_row, got.out_row);
			error_count++;
		end
		if (got.out_col !== exp_word.out_col) begin
			$error("out_col: expected %0d, actual %0d", exp_word.out_col, got.out_col);
			error_count++;
		end
		if (got.last_of_frame !== exp_word.last_of_frame) begin
			$error("last_of_frame: expected %0d, actual %0d",
				exp_word.last_of_frame, got.last_of_frame);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			check_result(res_if.data);
		res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic send_word(bin_ero_pkg::in_word_t word);
		while ($urandom_range(99) < source_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.data  <= word;
		do @(posedge clk); while (!pix_if.ready);
		if (predict_erosion(word))
			counted_items++;
	endtask

	task automatic send_op(logic op);
		bin_ero_pkg::in_word_t word;
		word.operation = op;
		if (op == bin_ero_pkg::OP_PIXEL)
			word.pixel_value = pattern_pixel(in_row, in_col);
		else
			word.pixel_value = 1'($urandom_range(1));
		send_word(word);
	endtask

	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(bin_ero_pkg::reg_idx_t idx, logic [CFG_W-1:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		apply_config(idx, value);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(int unsigned w, int unsigned h, logic [AREA-1:0] elem,
			logic inv);
		wait_idle();
		write_reg(bin_ero_pkg::REG_WIDTH, CFG_W'(w));
		write_reg(bin_ero_pkg::REG_HEIGHT, CFG_W'(h));
		write_reg(bin_ero_pkg::REG_ELEMENT, CFG_W'(elem));
		write_reg(bin_ero_pkg::REG_INVERT, CFG_W'(inv));
	endtask

	// Stray flushes mid-frame and stray pixels during the drain are noise.
	task automatic run_frame(int noise_pct);
		while (!frame_input_done()) begin
			if ($urandom_range(99) < noise_pct)
				send_op(bin_ero_pkg::OP_FLUSH);
			send_op(bin_ero_pkg::OP_PIXEL);
		end
		while (frame_input_done()) begin
			if ($urandom_range(99) < noise_pct)
				send_op(bin_ero_pkg::OP_PIXEL);
			send_op(bin_ero_pkg::OP_FLUSH);
		end
	endtask

	task automatic test_tiny_frame();
		configure(3, 2, AREA'($urandom()), 1'b0);
		pixel_pattern = PAT_RANDOM;
		repeat (3) send_op(bin_ero_pkg::OP_PIXEL);
		send_op(bin_ero_pkg::OP_FLUSH);
		while (!frame_input_done())
			send_op(bin_ero_pkg::OP_PIXEL);
		send_op(bin_ero_pkg::OP_PIXEL);
		while (frame_input_done())
			send_op(bin_ero_pkg::OP_FLUSH);
	endtask

	task automatic test_single_pixel();
		configure(0, 0, AREA'($urandom()), 1'b1);
		send_op(bin_ero_pkg::OP_PIXEL);
		send_op(bin_ero_pkg::OP_FLUSH);
		send_op(bin_ero_pkg::OP_FLUSH);
	endtask

	task automatic test_element_match();
		configure(5, 5, AREA'($urandom()), 1'b1);
		pixel_pattern = PAT_TILED;
		flip_pct = 0;
		run_frame(0);
		configure(5, 5, '1, 1'b0);
		pixel_pattern = PAT_SOLID;
		run_frame(0);
	endtask

	task automatic test_mid_frame_write();
		configure(7, 6, AREA'($urandom()), 1'b0);
		pixel_pattern = PAT_TILED;
		flip_pct = 0;
		repeat (16) send_op(bin_ero_pkg::OP_PIXEL);
		wait_idle();
		write_reg(bin_ero_pkg::REG_WIDTH, CFG_W'(4));
		write_reg(bin_ero_pkg::REG_ELEMENT, CFG_W'($urandom()));
		run_frame(0);
	endtask

	task automatic test_dimension_extremes();
		pixel_pattern = PAT_SOLID;
		configure(2047, 0, '1, 1'b0);
		repeat (12) send_op(bin_ero_pkg::OP_PIXEL);
		wait_idle();
		write_reg(bin_ero_pkg::REG_WIDTH, CFG_W'(13));
		run_frame(0);
		configure(0, 2047, '1, 1'b1);
		repeat (12) send_op(bin_ero_pkg::OP_PIXEL);
		wait_idle();
		write_reg(bin_ero_pkg::REG_HEIGHT, CFG_W'(14));
		run_frame(0);
	endtask

	task automatic test_random_frames(int target);
		int               start;
		int unsigned      w, h;
		logic [AREA-1:0]  elem;
		start = counted_items;
		while (counted_items - start < target) begin
			case ($urandom_range(9))
				0:       w = 0;
				1, 2:    w = $urandom_range(1, 4);
				default: w = $urandom_range(5, 12);
			endcase
			case ($urandom_range(9))
				0:       h = 0;
				1, 2:    h = $urandom_range(1, 4);
				default: h = $urandom_range(5, 10);
			endcase
			case ($urandom_range(4))
				0:       elem = '1;
				1:       elem = '0;
				default: elem = AREA'($urandom());
			endcase
			configure(w, h, elem, 1'($urandom_range(1)));
			case ($urandom_range(9))
				0, 1, 2:    pixel_pattern = PAT_RANDOM;
				3, 4:       pixel_pattern = PAT_SOLID;
				default:    pixel_pattern = PAT_TILED;
			endcase
			flip_pct = $urandom_range(0, 4);
			run_frame(8);
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		wr_en        <= 1'b0;
		wr_index     <= bin_ero_pkg::REG_WIDTH;
		wr_data      <= '0;
		pix_if.valid <= 1'b0;
		pix_if.data  <= '0;
		reset_erosion_model();
		source_idle_pct = 15;
		sink_idle_pct   = 84;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_tiny_frame();
		test_single_pixel();
		test_element_match();
		test_mid_frame_write();
		test_random_frames(90);
		source_idle_pct = 84;
		sink_idle_pct   = 15;
		test_random_frames(90);
		source_idle_pct = 0;
		sink_idle_pct   = 0;
		test_dimension_extremes();
		test_random_frames(90);
		wait_idle();
		if (expected_words.size() != 0) begin
			$error("%0d expected result words never arrived", expected_words.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bin_ero_pkg.sv
rtl/bin_ero_stream_if.sv
rtl/bin_ero_line_ram.sv
rtl/bin_ero_window.sv
rtl/binary_erosion_5x5_stream.sv
bench/binary_erosion_5x5_stream_tb.sv
